### src/voxel_grid_downsampler_macros.svh
// Assertion helpers for the voxel grid downsampler RTL.
`ifndef VOXEL_GRID_DOWNSAMPLER_MACROS_SVH
`define VOXEL_GRID_DOWNSAMPLER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define VGD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define VGD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/vgd_pkg.sv
// ----------------------------------------------------------------------------
// vgd_pkg
// Shared constants, register codes and types of the voxel grid downsampler.
// ----------------------------------------------------------------------------
package vgd_pkg;

   localparam int COORD_W     = 32;
   localparam int LEAF_W      = 31;
   localparam int DIMS_W      = 15;
   localparam int DIM_FIELD_W = 5;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   localparam logic [LEAF_W-1:0] LEAF_RESET = 31'd65536;
   localparam logic [DIMS_W-1:0] DIMS_RESET = 15'h7fff;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef enum logic [2:0] {
      REG_LEAF_SIZE,
      REG_ORIGIN_X,
      REG_ORIGIN_Y,
      REG_ORIGIN_Z,
      REG_CENTER_X,
      REG_CENTER_Y,
      REG_CENTER_Z,
      REG_GRID_DIMS
   } vgd_reg_type;

   typedef struct packed {
      logic [LEAF_W-1:0]             leaf_size;
      logic [2:0][COORD_W-1:0]       origin;
      logic [2:0][COORD_W-1:0]       center;
      logic [DIMS_W-1:0]             grid_dims;
   } vgd_cfg_type;

endpackage

### src/vgd_ram.sv
// ----------------------------------------------------------------------------
// vgd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vgd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### src/vgd_div.sv
// ----------------------------------------------------------------------------
// vgd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vgd_div #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot,
   output logic [DEN_W-1:0] rem
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   always_comb begin
      trial   = {rem_ff, num_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = trial >= {1'b0, den_ff};
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], ge};
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = num_ff;
   assign rem  = rem_ff;

endmodule

### src/vgd_fifo.sv
// ----------------------------------------------------------------------------
// vgd_fifo
// Short queue of binned items between the front and back parts.
// ----------------------------------------------------------------------------
module vgd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             do_push, do_pop;

   assign push_ready = cnt_ff != CNT_W'(DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_data   = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop);
      end
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

### src/vgd_front.sv
// ----------------------------------------------------------------------------
// vgd_front
// Accepts items, bins added points into a voxel address, queues the result.
// ----------------------------------------------------------------------------
module vgd_front #(
   parameter int GRID_SIDE = 16,
   localparam int ADDR_W = $clog2(GRID_SIDE * GRID_SIDE * GRID_SIDE),
   localparam int ITEM_W = 1 + ADDR_W + 3 * vgd_pkg::COORD_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  vgd_pkg::vgd_cfg_type  cfg,
   input  logic                  clearing,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [3*vgd_pkg::COORD_W-1:0] req_tdata,
   input  logic                  req_tuser,
   output logic                  push_valid,
   input  logic                  push_ready,
   output logic [ITEM_W-1:0]     push_data
);

   import vgd_pkg::*;

   localparam int IDX_W = $clog2(GRID_SIDE);
   localparam int LIM_W = 7;

   typedef enum logic [1:0] {F_IDLE, F_AXIS, F_DIV, F_PUSH} state_type;

   state_type                 state_ff, state_in;
   logic                      op_ff, op_in;
   logic [2:0][COORD_W-1:0]   pts_ff, pts_in;
   logic [1:0]                axis_ff, axis_in;
   logic [ADDR_W-1:0]         addr_ff, addr_in;

   logic [COORD_W-1:0]        p_sel, o_sel, c_sel;
   logic [DIM_FIELD_W-1:0]    field;
   logic [COORD_W:0]          diff;
   logic                      d_neg;
   logic                      div_start, div_done;
   logic [COORD_W-1:0]        quot;
   logic [LEAF_W-1:0]         rem;
   logic                      rem_nz, p_lt_c, p_gt_c, nudge;
   logic [COORD_W-1:0]        rem2, leaf32;
   logic [COORD_W:0]          q_full;
   logic [LIM_W-1:0]          lim;
   logic [IDX_W-1:0]          idx;
   logic [ADDR_W-1:0]         addr_next;
   logic                      step;

   vgd_div #(.NUM_W(COORD_W), .DEN_W(LEAF_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (diff[COORD_W-1:0]),
      .den   (cfg.leaf_size),
      .done  (div_done),
      .quot  (quot),
      .rem   (rem)
   );

   always_comb begin
      p_sel  = pts_ff[axis_ff];
      o_sel  = cfg.origin[axis_ff];
      c_sel  = cfg.center[axis_ff];
      field  = cfg.grid_dims[axis_ff * DIM_FIELD_W +: DIM_FIELD_W];
      diff   = {p_sel[COORD_W-1], p_sel} - {o_sel[COORD_W-1], o_sel};
      d_neg  = diff[COORD_W];
      // The ceiling never lands above the upper bound, so only the
      // downward nudge can apply: it depends on twice the remainder vs leaf.
      rem_nz = rem != '0;
      rem2   = {rem, 1'b0};
      leaf32 = {1'b0, cfg.leaf_size};
      p_lt_c = $signed(p_sel) < $signed(c_sel);
      p_gt_c = $signed(p_sel) > $signed(c_sel);
      nudge  = rem_nz && ((p_lt_c && (rem2 < leaf32)) || (p_gt_c && (rem2 <= leaf32)));
      q_full = {1'b0, quot} + (COORD_W + 1)'(rem_nz && !nudge);
      lim    = ({2'b00, field} > LIM_W'(GRID_SIDE - 1)) ? LIM_W'(GRID_SIDE - 1)
                                                        : {2'b00, field};
      if (d_neg || state_ff != F_DIV) begin
         idx = '0;
      end else if (q_full > (COORD_W + 1)'(lim)) begin
         idx = lim[IDX_W-1:0];
      end else begin
         idx = q_full[IDX_W-1:0];
      end
      addr_next = ADDR_W'(addr_ff * GRID_SIDE) + ADDR_W'(idx);
   end

   assign req_tready = (state_ff == F_IDLE) && !clearing;
   assign div_start  = (state_ff == F_AXIS) && !d_neg;
   assign step       = ((state_ff == F_AXIS) && d_neg) || ((state_ff == F_DIV) && div_done);
   assign push_valid = state_ff == F_PUSH;
   assign push_data  = {op_ff, addr_ff, pts_ff};

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      pts_in   = pts_ff;
      axis_in  = axis_ff;
      addr_in  = addr_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_tvalid && req_tready) begin
               op_in   = req_tuser;
               pts_in  = req_tdata;
               axis_in = '0;
               addr_in = '0;
               if (req_tuser == OP_DRAIN) begin
                  state_in = F_PUSH;
               end else if (cfg.leaf_size != '0) begin
                  state_in = F_AXIS;
               end
            end
         end
         F_AXIS, F_DIV: begin
            if (step) begin
               addr_in = addr_next;
               if (axis_ff == 2'd2) begin
                  state_in = F_PUSH;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = F_AXIS;
               end
            end else if (state_ff == F_AXIS) begin
               state_in = F_DIV;
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff   <= op_in;
      pts_ff  <= pts_in;
      axis_ff <= axis_in;
      addr_ff <= addr_in;
   end

endmodule

### src/vgd_back.sv
// ----------------------------------------------------------------------------
// vgd_back
// Accumulates points into the voxel store, walks it on drain requests,
// forms rounded means and clears the store after reset and after a finished drain.
// ----------------------------------------------------------------------------
module vgd_back #(
   parameter int GRID_SIDE  = 16,
   parameter int COUNT_BITS = 16,
   localparam int ADDR_W = $clog2(GRID_SIDE * GRID_SIDE * GRID_SIDE),
   localparam int ITEM_W = 1 + ADDR_W + 3 * vgd_pkg::COORD_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  logic [ITEM_W-1:0]     pop_data,
   output logic                  clearing,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [3*vgd_pkg::COORD_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   import vgd_pkg::*;

   localparam int DEPTH  = GRID_SIDE * GRID_SIDE * GRID_SIDE;
   localparam int CUR_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = COORD_W + COUNT_BITS;
   localparam int WORD_W = 3 * SUM_W + COUNT_BITS;
   localparam int MNUM_W = SUM_W + 1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [MNUM_W-1:0] NEG_LIM = MNUM_W'(64'h8000_0000);
   localparam logic [MNUM_W-1:0] POS_LIM = MNUM_W'(64'h7fff_ffff);

   typedef enum logic [3:0] {
      B_CLEAR, B_IDLE, B_ADD_WR, B_SCAN_RD, B_SCAN_CHK, B_MEAN, B_MEAN_WAIT,
      B_LOOK_RD, B_LOOK_CHK, B_SEND
   } state_type;

   state_type                 state_ff, state_in;
   logic [CUR_W-1:0]          scan_ff, scan_in;
   logic [CUR_W-1:0]          cursor_ff, cursor_in;
   logic [ADDR_W-1:0]         addr_ff, addr_in;
   logic [2:0][COORD_W-1:0]   pts_ff, pts_in;
   logic [2:0][SUM_W-1:0]     sum_ff, sum_in;
   logic [COUNT_BITS-1:0]     cnt_ff, cnt_in;
   logic [1:0]                axis_ff, axis_in;
   logic [2:0][COORD_W-1:0]   mean_ff, mean_in;
   logic                      found_ff, found_in;
   logic                      last_ff, last_in;
   logic                      fin_ff, fin_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [2:0][COORD_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      ram_we;
   logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
   logic [WORD_W-1:0]         ram_wdata, ram_rdata;
   logic [2:0][SUM_W-1:0]     rd_sum;
   logic [COUNT_BITS-1:0]     rd_cnt;
   logic [2:0][SUM_W-1:0]     add_sum;

   logic [SUM_W-1:0]          s_sel, mag;
   logic                      s_neg;
   logic [MNUM_W-1:0]         div_num, div_quot;
   logic [COUNT_BITS-1:0]     div_rem;
   logic                      div_start, div_done;
   logic [COORD_W-1:0]        mean_res;

   logic                      pop_op;
   logic [ADDR_W-1:0]         pop_addr;

   vgd_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   vgd_div #(.NUM_W(MNUM_W), .DEN_W(COUNT_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (cnt_ff),
      .done  (div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   assign rd_sum   = ram_rdata[3*SUM_W-1:0];
   assign rd_cnt   = ram_rdata[3*SUM_W +: COUNT_BITS];
   assign pop_op   = pop_data[ITEM_W-1];
   assign pop_addr = pop_data[3*COORD_W +: ADDR_W];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         add_sum[k] = rd_sum[k] + {{(SUM_W-COORD_W){pts_ff[k][COORD_W-1]}}, pts_ff[k]};
      end
      // Round half away from zero on the magnitude, then saturate to 32 bits.
      s_sel   = sum_ff[axis_ff];
      s_neg   = s_sel[SUM_W-1];
      mag     = s_neg ? (SUM_W'(0) - s_sel) : s_sel;
      div_num = {1'b0, mag} + MNUM_W'(cnt_ff >> 1);
      if (s_neg) begin
         mean_res = 32'd0 - ((div_quot > NEG_LIM) ? 32'h8000_0000 : div_quot[COORD_W-1:0]);
      end else begin
         mean_res = (div_quot > POS_LIM) ? 32'h7fff_ffff : div_quot[COORD_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      cursor_in    = cursor_ff;
      addr_in      = addr_ff;
      pts_in       = pts_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      axis_in      = axis_ff;
      mean_in      = mean_ff;
      found_in     = found_ff;
      last_in      = last_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_found_in = rsp_found_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_waddr    = addr_ff;
      ram_wdata    = '0;
      ram_raddr    = scan_ff[ADDR_W-1:0];
      pop_ready    = 1'b0;
      div_start    = 1'b0;
      case (state_ff)
         B_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = scan_ff[ADDR_W-1:0];
            if (scan_ff == CUR_W'(DEPTH - 1)) begin
               cursor_in = '0;
               state_in  = B_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         B_IDLE: begin
            pop_ready = 1'b1;
            ram_raddr = pop_addr;
            if (pop_valid) begin
               if (pop_op == OP_ADD) begin
                  addr_in  = pop_addr;
                  pts_in   = pop_data[3*COORD_W-1:0];
                  state_in = B_ADD_WR;
               end else begin
                  scan_in  = cursor_ff;
                  state_in = B_SCAN_RD;
               end
            end
         end
         B_ADD_WR: begin
            // Drop the point once the voxel count has saturated.
            if (rd_cnt != COUNT_MAX) begin
               ram_we    = 1'b1;
               ram_wdata = {rd_cnt + 1'b1, add_sum};
            end
            state_in = B_IDLE;
         end
         B_SCAN_RD: begin
            if (scan_ff == CUR_W'(DEPTH)) begin
               mean_in  = '0;
               found_in = 1'b0;
               last_in  = 1'b0;
               fin_in   = 1'b1;
               state_in = B_SEND;
            end else begin
               state_in = B_SCAN_CHK;
            end
         end
         B_SCAN_CHK: begin
            if (rd_cnt != '0) begin
               sum_in    = rd_sum;
               cnt_in    = rd_cnt;
               ram_we    = 1'b1;
               ram_waddr = scan_ff[ADDR_W-1:0];
               cursor_in = scan_ff + 1'b1;
               axis_in   = '0;
               found_in  = 1'b1;
               fin_in    = 1'b0;
               state_in  = B_MEAN;
            end else begin
               state_in = B_SCAN_RD;
            end
            scan_in = scan_ff + 1'b1;
         end
         B_MEAN: begin
            div_start = 1'b1;
            state_in  = B_MEAN_WAIT;
         end
         B_MEAN_WAIT: begin
            if (div_done) begin
               mean_in[axis_ff] = mean_res;
               if (axis_ff == 2'd2) begin
                  state_in = B_LOOK_RD;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = B_MEAN;
               end
            end
         end
         B_LOOK_RD: begin
            if (scan_ff == CUR_W'(DEPTH)) begin
               last_in  = 1'b1;
               state_in = B_SEND;
            end else begin
               state_in = B_LOOK_CHK;
            end
         end
         B_LOOK_CHK: begin
            if (rd_cnt != '0) begin
               last_in  = 1'b0;
               state_in = B_SEND;
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = B_LOOK_RD;
            end
         end
         B_SEND: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mean_ff;
               rsp_found_in = found_ff;
               rsp_last_in  = last_ff;
               if (fin_ff) begin
                  scan_in   = '0;
                  cursor_in = '0;
                  state_in  = B_CLEAR;
               end else begin
                  state_in = B_IDLE;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         scan_ff      <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         fin_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
         fin_ff       <= fin_in;
      end
      addr_ff      <= addr_in;
      pts_ff       <= pts_in;
      sum_ff       <= sum_in;
      cnt_ff       <= cnt_in;
      axis_ff      <= axis_in;
      mean_ff      <= mean_in;
      found_ff     <= found_in;
      last_ff      <= last_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign clearing   = state_ff == B_CLEAR;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### src/voxel_grid_downsampler.sv
// ----------------------------------------------------------------------------
// voxel_grid_downsampler: bins Q16.16 points into voxels, drains voxel means.
// Add: the front bins each axis with a serial 32-bit divider; the back reads and
// rewrites the voxel. Drain: the back scans the store for the next filled voxel
// and forms its means with one serial division per axis. Front and back overlap
// through a 4-entry queue. Reset and every finished drain clear all GRID_SIDE^3
// entries (4096 by default), accepting no item meanwhile; csr writes still land.
// ----------------------------------------------------------------------------
`include "voxel_grid_downsampler_macros.svh"

module voxel_grid_downsampler #(
   parameter int GRID_SIDE  = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [3*vgd_pkg::COORD_W-1:0]     req_tdata,   // point_x, point_y, point_z
   input  logic                              req_tuser,   // operation
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [3*vgd_pkg::COORD_W-1:0]     rsp_tdata,   // mean_x, mean_y, mean_z
   output logic                              rsp_tuser,   // found
   output logic                              rsp_tlast,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [vgd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [vgd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [vgd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   import vgd_pkg::*;

   localparam int ADDR_W = $clog2(GRID_SIDE * GRID_SIDE * GRID_SIDE);
   localparam int ITEM_W = 1 + ADDR_W + 3 * COORD_W;

   logic [LEAF_W-1:0]       leaf_ff, leaf_in;
   logic [2:0][COORD_W-1:0] origin_ff, origin_in;
   logic [2:0][COORD_W-1:0] center_ff, center_in;
   logic [DIMS_W-1:0]       dims_ff, dims_in;
   vgd_cfg_type             cfg;
   vgd_reg_type             reg_sel;
   logic                    csr_wr;

   logic                    push_valid, push_ready, pop_valid, pop_ready;
   logic [ITEM_W-1:0]       push_data, pop_data;
   logic                    back_clearing;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = vgd_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      leaf_in   = leaf_ff;
      origin_in = origin_ff;
      center_in = center_ff;
      dims_in   = dims_ff;
      if (csr_wr) begin
         case (reg_sel)
            REG_LEAF_SIZE: leaf_in      = csr_pwdata[LEAF_W-1:0];
            REG_ORIGIN_X:  origin_in[0] = csr_pwdata;
            REG_ORIGIN_Y:  origin_in[1] = csr_pwdata;
            REG_ORIGIN_Z:  origin_in[2] = csr_pwdata;
            REG_CENTER_X:  center_in[0] = csr_pwdata;
            REG_CENTER_Y:  center_in[1] = csr_pwdata;
            REG_CENTER_Z:  center_in[2] = csr_pwdata;
            REG_GRID_DIMS: dims_in      = csr_pwdata[DIMS_W-1:0];
            default: ;
         endcase
      end
      case (reg_sel)
         REG_LEAF_SIZE: csr_prdata = {1'b0, leaf_ff};
         REG_ORIGIN_X:  csr_prdata = origin_ff[0];
         REG_ORIGIN_Y:  csr_prdata = origin_ff[1];
         REG_ORIGIN_Z:  csr_prdata = origin_ff[2];
         REG_CENTER_X:  csr_prdata = center_ff[0];
         REG_CENTER_Y:  csr_prdata = center_ff[1];
         REG_CENTER_Z:  csr_prdata = center_ff[2];
         REG_GRID_DIMS: csr_prdata = {{(CSR_DATA_W-DIMS_W){1'b0}}, dims_ff};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leaf_ff   <= LEAF_RESET;
         origin_ff <= '0;
         center_ff <= '0;
         dims_ff   <= DIMS_RESET;
      end else begin
         leaf_ff   <= leaf_in;
         origin_ff <= origin_in;
         center_ff <= center_in;
         dims_ff   <= dims_in;
      end
   end

   assign cfg.leaf_size = leaf_ff;
   assign cfg.origin    = origin_ff;
   assign cfg.center    = center_ff;
   assign cfg.grid_dims = dims_ff;

   vgd_front #(.GRID_SIDE(GRID_SIDE)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .clearing   (back_clearing),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   vgd_fifo #(.WIDTH(ITEM_W), .DEPTH(4)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   vgd_back #(.GRID_SIDE(GRID_SIDE), .COUNT_BITS(COUNT_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .clearing   (back_clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   `VGD_ASSERT_IMPL(a_no_accept_in_clear, clock, reset, back_clearing, !req_tready, "item accepted during store clear")
   `VGD_ASSERT_IMPL(a_finish_is_zero, clock, reset, rsp_tvalid && !rsp_tuser, (rsp_tdata == '0) && !rsp_tlast, "drain-finished result not zero")
   `VGD_ASSERT_IMPL(a_finish_clears, clock, reset, $rose(rsp_tvalid) && !rsp_tuser, back_clearing, "store not cleared after drain finish")
   `VGD_ASSERT_NEXT(a_reset_clears, clock, reset, $past(reset), back_clearing, "no clearing pass after reset")

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// Voxel grid downsampler testbench
// Streams add and drain items over the request channel under random idling
// and back pressure. A local voxel store is updated on every accepted item,
// and each drained mean is checked field by field against it.
// ----------------------------------------------------------------------------
module testbench;
   import vgd_pkg::*;

   localparam int SIDE      = 16;
   localparam int CNT_BITS  = 16;
   localparam int DEPTH     = SIDE * SIDE * SIDE;
   localparam int CNT_MAX   = (1 << CNT_BITS) - 1;
   localparam int HOLD_CYC  = 6000;
   localparam int SETTLE    = 600;
   localparam int TAIL      = 5000;

   typedef struct packed {
      logic              op;
      logic [31:0]       x;
      logic [31:0]       y;
      logic [31:0]       z;
   } point_item_t;

   typedef struct packed {
      logic [31:0]       mx;
      logic [31:0]       my;
      logic [31:0]       mz;
      logic              found;
      logic              last;
   } voxel_mean_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;   // point_x, point_y, point_z
   logic        req_tuser = 1'b0; // operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;        // mean_x, mean_y, mean_z
   logic        rsp_tuser;        // found
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic        csr_pready;

   voxel_grid_downsampler #(.GRID_SIDE(SIDE), .COUNT_BITS(CNT_BITS)) i_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // local copy of configuration and voxel store
   longint      leaf;
   longint      org[3];
   longint      ctr[3];
   int unsigned dims;
   longint      sum_x[DEPTH];
   longint      sum_y[DEPTH];
   longint      sum_z[DEPTH];
   int unsigned vox_cnt[DEPTH];
   int unsigned cursor;

   point_item_t pending[$];
   voxel_mean_t mean_queue[$];
   point_item_t cur_item = '0;
   int unsigned offered_n = 0;
   int unsigned accepted_n = 0;
   bit          quiet = 1'b0;
   bit          pressure = 1'b0;
   int unsigned hold_cnt = 0;
   bit          failed = 1'b0;

   function automatic void clear_voxels();
      for (int a = 0; a < DEPTH; a++) begin
         sum_x[a] = 0; sum_y[a] = 0; sum_z[a] = 0; vox_cnt[a] = 0;
      end
      cursor = 0;
   endfunction

   function automatic int unsigned bin_axis(longint p, int ax);
      longint o, d, q, l, p2, lo2, hi2, lim;
      o = org[ax];
      d = p - o;
      q = 0;
      if (d >= 0) begin
         l = leaf;
         q = (d + l - 1) / l;
         p2 = 2 * p;
         lo2 = 2 * o + 2 * q * l - l;
         hi2 = 2 * o + 2 * q * l + l;
         // tie rule flips with the side of the center
         if (p < ctr[ax]) begin
            if (p2 < lo2) q--;
            else if (p2 >= hi2) q++;
         end else if (p > ctr[ax]) begin
            if (p2 <= lo2) q--;
            else if (p2 > hi2) q++;
         end
         if (q < 0) q = 0;
      end
      lim = (dims >> (5 * ax)) & 31;
      if (lim > SIDE - 1) lim = SIDE - 1;
      if (q > lim) q = lim;
      return int'(q);
   endfunction

   function automatic logic [31:0] voxel_mean(longint s, int unsigned cnt);
      longint mag, q, c;
      c = cnt;
      mag = (s < 0) ? -s : s;
      q = (mag + c / 2) / c;
      if (s < 0) begin
         if (q > 64'sh8000_0000) q = 64'sh8000_0000;
         q = -q;
      end else if (q > 64'sh7fff_ffff) begin
         q = 64'sh7fff_ffff;
      end
      return q[31:0];
   endfunction

   function automatic void apply_item(point_item_t it);
      int unsigned a, n;
      longint px, py, pz;
      voxel_mean_t m;
      if (it.op == OP_ADD) begin
         if (leaf == 0) return;
         px = longint'($signed(it.x));
         py = longint'($signed(it.y));
         pz = longint'($signed(it.z));
         a = (bin_axis(px, 0) * SIDE + bin_axis(py, 1)) * SIDE + bin_axis(pz, 2);
         if (vox_cnt[a] >= CNT_MAX) return;
         sum_x[a] += px; sum_y[a] += py; sum_z[a] += pz;
         vox_cnt[a]++;
         return;
      end
      a = cursor;
      while (a < DEPTH && vox_cnt[a] == 0) a++;
      if (a >= DEPTH) begin
         clear_voxels();
         mean_queue.push_back('0);
         return;
      end
      m.mx = voxel_mean(sum_x[a], vox_cnt[a]);
      m.my = voxel_mean(sum_y[a], vox_cnt[a]);
      m.mz = voxel_mean(sum_z[a], vox_cnt[a]);
      m.found = 1'b1;
      sum_x[a] = 0; sum_y[a] = 0; sum_z[a] = 0; vox_cnt[a] = 0;
      cursor = a + 1;
      n = a + 1;
      while (n < DEPTH && vox_cnt[n] == 0) n++;
      m.last = (n >= DEPTH);
      mean_queue.push_back(m);
   endfunction

   // driver: hold an offered item until it is taken
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || accepted_n == offered_n) begin
         if (pending.size() > 0 && (quiet || $urandom_range(99) >= 17)) begin
            cur_item <= pending[0];
            req_tdata <= {pending[0].z, pending[0].y, pending[0].x};
            req_tuser <= pending[0].op;
            req_tvalid <= 1'b1;
            offered_n <= offered_n + 1;
            void'(pending.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (pressure && hold_cnt < HOLD_CYC) begin
         rsp_tready <= 1'b0;
         hold_cnt <= hold_cnt + 1;
      end else begin
         rsp_tready <= quiet || $urandom_range(99) >= 17;
      end
   end

   // monitor
   always @(posedge clock) begin
      voxel_mean_t e;
      if (!reset && req_tvalid && req_tready) begin
         apply_item(cur_item);
         accepted_n++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (mean_queue.size() == 0) begin
            $error("unexpected result item: tdata %h found %b last %b",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            failed = 1'b1;
         end else begin
            e = mean_queue.pop_front();
            if (rsp_tdata[31:0] !== e.mx) begin
               $error("mean_x expected %h actual %h", e.mx, rsp_tdata[31:0]);
               failed = 1'b1;
            end
            if (rsp_tdata[63:32] !== e.my) begin
               $error("mean_y expected %h actual %h", e.my, rsp_tdata[63:32]);
               failed = 1'b1;
            end
            if (rsp_tdata[95:64] !== e.mz) begin
               $error("mean_z expected %h actual %h", e.mz, rsp_tdata[95:64]);
               failed = 1'b1;
            end
            if (rsp_tuser !== e.found) begin
               $error("found expected %b actual %b", e.found, rsp_tuser);
               failed = 1'b1;
            end
            if (rsp_tlast !== e.last) begin
               $error("last_voxel expected %b actual %b", e.last, rsp_tlast);
               failed = 1'b1;
            end
         end
      end
   end

   task automatic wait_idle();
      while (pending.size() != 0 || accepted_n != offered_n || mean_queue.size() != 0)
         @(posedge clock);
   endtask

   task automatic csr_write(vgd_reg_type r, logic [31:0] v);
      @(negedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(4 * int'(r)); csr_pwdata <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   task automatic set_config(logic [30:0] lf, logic [31:0] ox, logic [31:0] oy,
                             logic [31:0] oz, logic [31:0] cx, logic [31:0] cy,
                             logic [31:0] cz, logic [14:0] gd);
      wait_idle();
      repeat (SETTLE) @(posedge clock);
      csr_write(REG_LEAF_SIZE, {1'b0, lf});
      csr_write(REG_ORIGIN_X, ox);
      csr_write(REG_ORIGIN_Y, oy);
      csr_write(REG_ORIGIN_Z, oz);
      csr_write(REG_CENTER_X, cx);
      csr_write(REG_CENTER_Y, cy);
      csr_write(REG_CENTER_Z, cz);
      csr_write(REG_GRID_DIMS, {17'd0, gd});
      leaf = lf;
      org[0] = longint'($signed(ox)); org[1] = longint'($signed(oy));
      org[2] = longint'($signed(oz));
      ctr[0] = longint'($signed(cx)); ctr[1] = longint'($signed(cy));
      ctr[2] = longint'($signed(cz));
      dims = gd;
   endtask

   task automatic push_point(logic op, logic [31:0] x, logic [31:0] y, logic [31:0] z);
      point_item_t it;
      it.op = op; it.x = x; it.y = y; it.z = z;
      pending.push_back(it);
   endtask

   // empty the store: drain every voxel ahead of the cursor, then one more
   task automatic flush_voxels();
      int unsigned n;
      wait_idle();
      n = 0;
      for (int a = cursor; a < DEPTH; a++) if (vox_cnt[a] != 0) n++;
      repeat (n + 1) push_point(OP_DRAIN, $urandom, $urandom, $urandom);
      wait_idle();
   endtask

   function automatic logic [31:0] gen_coord(int ax);
      longint l, p;
      int unsigned r;
      r = $urandom_range(99);
      l = (leaf == 0) ? 65536 : leaf;
      if (r < 8) return $urandom;
      if (r < 12) return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      if (r < 17) return ctr[ax][31:0];
      p = org[ax] + longint'($urandom_range(17)) * l;
      case ($urandom_range(2))
         0: p = p + longint'($urandom) % l;
         1: p = p + l / 2 - 1 + longint'($urandom_range(2));
         default: p = p - l / 2 - 1 + longint'($urandom_range(2));
      endcase
      return p[31:0];
   endfunction

   task automatic random_phase(int n, int drain_pct);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < drain_pct)
            push_point(OP_DRAIN, $urandom, $urandom, $urandom);
         else
            push_point(OP_ADD, gen_coord(0), gen_coord(1), gen_coord(2));
      end
      flush_voxels();
   endtask

   task automatic random_config();
      logic [30:0] lf;
      logic [31:0] o[3], c[3];
      case ($urandom_range(4))
         0: lf = 31'd65536;
         1: lf = 31'($urandom_range(1, 1 << 20));
         2: lf = 31'(3 * 65536 + 1);
         3: lf = 31'($urandom_range(1, 64));
         default: lf = 31'($urandom);
      endcase
      for (int i = 0; i < 3; i++) begin
         o[i] = $urandom_range(3) == 0 ? $urandom : 32'($signed(24'($urandom)));
         c[i] = o[i] + 32'($urandom_range(16)) * 32'(lf);
      end
      set_config(lf, o[0], o[1], o[2], c[0], c[1], c[2], 15'($urandom));
   endtask

   initial begin
      leaf = LEAF_RESET;
      org = '{0, 0, 0};
      ctr = '{0, 0, 0};
      dims = DIMS_RESET;
      clear_voxels();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, center and half-voxel ties, below origin
      set_config(31'd65536, 32'd0, 32'd0, 32'd0, 32'h0001_8000, 32'h0002_8000,
                 32'h0000_8000, 15'h7fff);
      push_point(OP_DRAIN, '0, '0, '0);
      push_point(OP_ADD, 32'd0, 32'd0, 32'd0);
      push_point(OP_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      push_point(OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      push_point(OP_ADD, 32'h0001_8000, 32'h0002_8000, 32'h0000_8000);
      push_point(OP_ADD, 32'h0000_8000, 32'h0001_8000, 32'h0002_8000);
      push_point(OP_ADD, 32'h0002_8000, 32'h0003_8000, 32'h0001_8000);
      push_point(OP_ADD, 32'hffff_ffff, 32'h0000_0001, 32'h0001_0000);
      push_point(OP_DRAIN, '1, '1, '1);
      push_point(OP_ADD, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
      push_point(OP_ADD, 32'h7fff_ffff, 32'h0, 32'h8000_0000);
      flush_voxels();

      // zero leaf: adds are dropped
      set_config(31'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 15'h0);
      repeat (3) push_point(OP_ADD, $urandom, $urandom, $urandom);
      flush_voxels();

      // many points on one voxel, largest leaf, flat grid
      set_config(31'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 15'h0);
      repeat (40) push_point(OP_ADD, 32'h1234_5678, 32'h8765_4321, 32'hffff_0000);
      push_point(OP_ADD, 32'h8000_0000, 32'h0, 32'h7fff_ffff);
      flush_voxels();

      // smallest leaf, odd bounds
      set_config(31'd1, 32'hffff_fff8, 32'd0, 32'd3, 32'd0, 32'd4, 32'hffff_fffc, 15'h7fff);
      random_phase(80, 10);

      for (int ph = 0; ph < 8; ph++) begin
         random_config();
         quiet = (ph == 2);
         random_phase(80, 12);
      end
      quiet = 1'b0;

      // block fills while results are held back
      random_config();
      pressure = 1'b1;
      random_phase(160, 40);
      pressure = 1'b0;

      set_config(LEAF_RESET, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, DIMS_RESET);
      random_phase(80, 10);

      wait_idle();
      repeat (TAIL) @(posedge clock);
      if (!failed && mean_queue.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #600_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
